[sv/sitda_pkg.sv]
// shared types and constants for the signed integer to decimal ascii converter
package sitda_pkg;

    localparam int NUM_DIGITS = 10;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [7:0]  CHAR_ZERO  = 8'd48;
    localparam logic [7:0]  CHAR_MINUS = 8'd45;

    // ceil(2^35 / 10): (x * RECIP_TEN) >> 35 equals x / 10 for any 32-bit x
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic dec;
        logic sel_sign;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic neg;
        logic conv_done;
        logic idx_zero;
    } status_t;

endpackage

[sv/sitda_ctrl.sv]
// controller state machine: sequences load, digit extraction and character output
module sitda_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  sitda_pkg::status_t status,
    output sitda_pkg::cmd_t    cmd
);

    sitda_pkg::state_t state_reg;
    sitda_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sitda_pkg::ST_CONVERT;
                end
            end
            sitda_pkg::ST_CONVERT:
            begin
                if (status.conv_done)
                begin
                    state_next = status.neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_SIGN:
            begin
                if (!out_stall)
                begin
                    state_next = sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_EMIT:
            begin
                if (!out_stall && status.idx_zero)
                begin
                    state_next = sitda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sitda_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        cmd          = '0;
        case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            sitda_pkg::ST_CONVERT:
            begin
                cmd.step = 1'b1;
            end
            sitda_pkg::ST_SIGN:
            begin
                out_valid    = 1'b1;
                cmd.sel_sign = 1'b1;
            end
            sitda_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.dec   = !out_stall && !status.idx_zero;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[sv/sitda_datapath.sv]
// datapath: magnitude, divide-by-ten step, digit buffer and character formation
module sitda_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] value,
    input  sitda_pkg::cmd_t     cmd,
    output sitda_pkg::status_t  status,
    output logic [7:0]         character,
    output logic               last
);

    logic [31:0]                  mag_reg;
    logic [31:0]                  mag_next;
    logic                         neg_reg;
    logic                         neg_next;
    logic [sitda_pkg::IDX_W-1:0]  idx_reg;
    logic [sitda_pkg::IDX_W-1:0]  idx_next;
    logic [3:0]                   digits_reg [sitda_pkg::NUM_DIGITS];

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] quot_x10;
    logic [31:0] rem_full;
    logic [3:0]  rem;
    logic        conv_done;

    // divide by ten through reciprocal multiply
    assign prod     = {32'd0, mag_reg} * {32'd0, sitda_pkg::RECIP_TEN};
    assign quot     = {3'd0, prod[63:sitda_pkg::RECIP_SHIFT]};
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = mag_reg - quot_x10;
    assign rem      = rem_full[3:0];

    assign conv_done = (quot == 32'd0) || (idx_reg == sitda_pkg::IDX_LAST);

    // next values for magnitude, sign and digit index
    always_comb
    begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        idx_next = idx_reg;
        if (cmd.load)
        begin
            neg_next = value[31];
            mag_next = value[31] ? (~value + 32'd1) : value;
            idx_next = '0;
        end
        else if (cmd.step)
        begin
            mag_next = quot;
            if (!conv_done)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (cmd.dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            neg_reg <= neg_next;
            idx_reg <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (cmd.step)
        begin
            digits_reg[idx_reg] <= rem;
        end
    end

    assign status.neg       = neg_reg;
    assign status.conv_done = conv_done;
    assign status.idx_zero  = (idx_reg == '0);

    // output character, digits read from most significant down
    always_comb
    begin
        if (cmd.sel_sign)
        begin
            character = sitda_pkg::CHAR_MINUS;
            last      = 1'b0;
        end
        else
        begin
            character = sitda_pkg::CHAR_ZERO + {4'd0, digits_reg[idx_reg]};
            last      = (idx_reg == '0);
        end
    end

endmodule

[sv/signed_int_to_decimal_ascii.sv]
// top level: signed 32-bit integer to decimal ascii character stream
// sequence: request accepted, then one divide-by-ten per extraction step for 1 to 10 digits,
// first character offered on the following cycle
// input: one value at a time, a new request is taken only once the last character has been sent;
// a text holds at most 11 characters, its digits all come from the single divide-by-ten unit
// reset: asynchronous active-low rst_n returns the controller to idle, no output valid
module signed_int_to_decimal_ascii
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         character,
    output logic               last
);

    sitda_pkg::cmd_t    cmd;
    sitda_pkg::status_t status;

    // controller
    sitda_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    sitda_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (last)
    );

    // no new request is taken while characters are being sent
    a_busy_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while output is active");

    // an accepted request blocks the input on the next cycle
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // final character ends the text
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !out_valid)
        else $error("output continued after last character");

    // minus sign is never the final character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && character == sitda_pkg::CHAR_MINUS) |-> !last)
        else $error("minus sign flagged as last");

endmodule
